@@ hdl/ljpf_pkg.sv @@
// Shared constants, types and Q16.16 helper functions of the LJ pair force unit.
`default_nettype none
package ljpf_pkg;

    localparam int NUM_ATOMS = 1024;
    localparam int ATOM_W    = $clog2(NUM_ATOMS);
    localparam int MEM_DEPTH = 3 * NUM_ATOMS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [30:0]        BOX_RST   = 31'd655360;
    localparam logic [30:0]        CUT_RST   = 31'd409600;
    localparam logic signed [31:0] SHIFT_RST = -32'sd1067;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] Q_HALF  = 66'sd32768;
    localparam logic signed [65:0] Q_ONE   = 66'sd65536;

    // Command codes carried in tuser
    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_PAIR  = 2'd1,
        FN_READ  = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BOX   = 2'd0,
        CFG_CUT   = 2'd1,
        CFG_SHIFT = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_LOAD = 9'b000000010,
        S_PRD  = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_MUL  = 9'b000100000,
        S_FUPD = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'(S32_MAX))
                r = S32_MAX;
            else if (v < 66'(S32_MIN))
                r = S32_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    // Q16.16 product: round to nearest with halves up, then saturate
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
        logic signed [64:0] s;
        begin
            s = 65'(p) + 65'sd32768;
            return sat32(66'(s >>> 16));
        end
    endfunction

    // Word address of one axis of one atom
    function automatic logic [MEM_AW-1:0] addr3(input logic [ATOM_W-1:0] a,
                                               input logic [1:0] k);
        begin
            return MEM_AW'({a, 1'b0}) + MEM_AW'(a) + MEM_AW'(k);
        end
    endfunction

    // Minimum-image wrap of one axis, single fold at half a box
    function automatic logic signed [31:0] wrap_d(input logic signed [31:0] pa,
                                                 input logic signed [31:0] pb,
                                                 input logic [30:0] box);
        logic signed [33:0] v;
        logic signed [33:0] half;
        logic signed [33:0] bx;
        begin
            v    = 34'(pa) - 34'(pb);
            half = $signed({4'b0, box[30:1]});
            bx   = $signed({3'b0, box});
            if (v > half)
                v = v - bx;
            else if (v < -half)
                v = v + bx;
            return sat32(66'(v));
        end
    endfunction

endpackage
`default_nettype wire

@@ hdl/lj_pair_force_accumulator_unit.sv @@
// Top level of the Lennard-Jones pair force accumulator: sequencer, stores and shared multiplier.
`default_nettype none
// One item is taken at a time; s_tready is high only while the sequencer is idle.
// The time a pair takes is set by the bit-serial reciprocal divider (one quotient
// bit a cycle), by the single 32x32 multiplier that every product of the force and
// energy chain passes through in turn, and by the single read and write port of
// the force memory, which takes the read-modify-write of both atoms one word at a
// time. Position and force memories are not cleared at reset; an atom's force is
// zeroed when it is loaded, and an atom must be loaded before it is used in a pair
// or read.
module lj_pair_force_accumulator_unit
    import ljpf_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [119:0] s_tdata,   // atom_a, atom_b, pos_x, pos_y, pos_z, zero pad
    input  wire logic [1:0]   s_tuser,   // func
    // result stream
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [191:0] m_tdata,   // force_x, force_y, force_z, virial_term,
                                         // energy_sum, pair_count
    output      logic         m_tuser    // in_cutoff
);

    // configuration
    logic [30:0]        box_reg;
    logic [30:0]        cut_reg;
    logic signed [31:0] shift_reg;

    // sequencer
    state_t             state_reg;
    state_t             state_next;
    logic [5:0]         step_reg;

    // item fields
    func_t              func_reg;
    logic [ATOM_W-1:0]  a_reg;
    logic [ATOM_W-1:0]  b_reg;
    logic signed [31:0] pos_reg [3];

    // pair working registers
    logic signed [31:0] pa_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] f_reg [3];
    logic [63:0]        r2_reg;
    logic [31:0]        r2q_reg;
    logic [31:0]        rem_reg;
    logic [33:0]        num_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] r6i_reg;
    logic signed [31:0] g_reg;
    logic               hit_reg;

    // totals and result
    logic signed [31:0] energy_reg;
    logic [31:0]        count_reg;
    logic signed [31:0] fo_reg [3];
    logic signed [31:0] vir_reg;
    logic               m_tvalid_reg;
    logic [191:0]       m_tdata_reg;
    logic               m_tuser_reg;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_c;
    logic signed [63:0] prod_reg;
    logic signed [31:0] qm;

    // memories
    logic [31:0]        pos_mem [MEM_DEPTH];
    logic [31:0]        frc_mem [MEM_DEPTH];
    logic               pos_we;
    logic [MEM_AW-1:0]  pos_waddr;
    logic [31:0]        pos_wdata;
    logic [MEM_AW-1:0]  pos_raddr;
    logic signed [31:0] pos_rdata;
    logic               frc_we;
    logic [MEM_AW-1:0]  frc_waddr;
    logic [31:0]        frc_wdata;
    logic [MEM_AW-1:0]  frc_raddr;
    logic signed [31:0] frc_rdata;

    // misc combinational
    logic [63:0]        r2_rnd;
    logic [31:0]        r2q_c;
    logic [32:0]        trial;
    logic               div_ge;
    logic signed [31:0] r2i;
    logic [2:0]         fu_op;
    logic [1:0]         fu_k;
    logic [ATOM_W-1:0]  fu_atom;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // multiplier and its rounded Q16.16 view
    assign prod_c = mul_a * mul_b;
    assign qm     = rnd_sat(prod_reg);

    // squared distance rounded to Q16.16, never zero
    assign r2_rnd = r2_reg + 64'd32768;
    assign r2q_c  = (r2_rnd[47:16] == 32'd0) ? 32'd1 : r2_rnd[47:16];

    // divider step and saturated quotient
    assign trial  = {rem_reg, num_reg[33]};
    assign div_ge = (trial >= {1'b0, r2q_reg});
    assign r2i    = (num_reg[33:31] != 3'd0) ? S32_MAX : $signed({1'b0, num_reg[30:0]});

    // force update ordering: a then b per axis
    assign fu_op   = step_reg[3:1];
    assign fu_k    = fu_op[2:1];
    assign fu_atom = fu_op[0] ? b_reg : a_reg;

    // memory ports and multiplier operands
    always_comb
    begin
        pos_we    = 1'b0;
        pos_waddr = addr3(a_reg, step_reg[1:0]);
        pos_wdata = pos_reg[step_reg[1:0]];
        pos_raddr = addr3(a_reg, step_reg[1:0]);
        frc_we    = 1'b0;
        frc_waddr = addr3(a_reg, step_reg[1:0]);
        frc_wdata = 32'd0;
        frc_raddr = addr3(a_reg, step_reg[1:0]);
        mul_a     = 32'sd0;
        mul_b     = 32'sd0;
        case (state_reg)
            S_LOAD:
            begin
                pos_we = 1'b1;
                frc_we = 1'b1;
            end
            S_PRD:
            begin
                if (step_reg >= 6'd3)
                    pos_raddr = addr3(b_reg, 2'(step_reg - 6'd3));
            end
            S_SQ:
            begin
                mul_a = d_reg[step_reg[1:0]];
                mul_b = d_reg[step_reg[1:0]];
            end
            S_MUL:
            begin
                case (step_reg)
                    6'd0:
                    begin
                        mul_a = r2i;
                        mul_b = r2i;
                    end
                    6'd2:
                    begin
                        mul_a = t_reg;
                        mul_b = r2i;
                    end
                    6'd4:
                    begin
                        mul_a = sat32((66'(r2i) <<< 5) + (66'(r2i) <<< 4));
                        mul_b = r6i_reg;
                    end
                    6'd6:
                    begin
                        mul_a = t_reg;
                        mul_b = sat32(66'(r6i_reg) - Q_HALF);
                    end
                    6'd8:
                    begin
                        mul_a = sat32(66'(r6i_reg) <<< 2);
                        mul_b = sat32(66'(r6i_reg) - Q_ONE);
                    end
                    6'd10:
                    begin
                        mul_a = g_reg;
                        mul_b = d_reg[0];
                    end
                    6'd11:
                    begin
                        mul_a = g_reg;
                        mul_b = d_reg[1];
                    end
                    6'd12:
                    begin
                        mul_a = g_reg;
                        mul_b = d_reg[2];
                    end
                    default:
                    begin
                        mul_a = 32'sd0;
                        mul_b = 32'sd0;
                    end
                endcase
            end
            S_FUPD:
            begin
                frc_raddr = addr3(fu_atom, fu_k);
                frc_waddr = addr3(fu_atom, fu_k);
                frc_we    = step_reg[0];
                if (fu_op[0])
                    frc_wdata = sat32(66'(frc_rdata) - 66'(f_reg[fu_k]));
                else
                    frc_wdata = sat32(66'(frc_rdata) + 66'(f_reg[fu_k]));
            end
            S_OUT:
            begin
                mul_a = frc_rdata;
                mul_b = pos_rdata;
            end
            default:
            begin
                pos_we = 1'b0;
                frc_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (func_t'(s_tuser))
                        FN_LOAD:  state_next = S_LOAD;
                        FN_PAIR:  state_next = S_PRD;
                        FN_READ:  state_next = S_OUT;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD: if (step_reg == 6'd2) state_next = S_OUT;
            S_PRD:  if (step_reg == 6'd6) state_next = S_SQ;
            S_SQ:
            begin
                if (step_reg == 6'd4)
                    state_next = (r2_reg > {17'd0, cut_reg, 16'd0}) ? S_OUT : S_DIV;
            end
            S_DIV:  if (step_reg == 6'd33) state_next = S_MUL;
            S_MUL:  if (step_reg == 6'd13) state_next = S_FUPD;
            S_FUPD: if (step_reg == 6'd11) state_next = S_OUT;
            S_OUT:  if (step_reg == 6'd4) state_next = S_DONE;
            S_DONE: if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memories, no reset
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_waddr] <= pos_wdata;
        pos_rdata <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (frc_we)
            frc_mem[frc_waddr] <= frc_wdata;
        frc_rdata <= frc_mem[frc_raddr];
    end

    // multiplier output register
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_c;
    end

    // sequencer, datapath and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= 6'd0;
            box_reg      <= BOX_RST;
            cut_reg      <= CUT_RST;
            shift_reg    <= SHIFT_RST;
            energy_reg   <= 32'sd0;
            count_reg    <= 32'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_BOX:   box_reg   <= cfg_wdata[30:0];
                    CFG_CUT:   cut_reg   <= cfg_wdata[30:0];
                    CFG_SHIFT: shift_reg <= cfg_wdata;
                    default:   box_reg   <= box_reg;
                endcase
            end

            // result valid: raised when a beat is presented, dropped once taken
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            state_reg <= state_next;
            if (state_next != state_reg)
                step_reg <= 6'd0;
            else
                step_reg <= step_reg + 6'd1;

            case (state_reg)
                // latch the item
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg   <= func_t'(s_tuser);
                        a_reg      <= s_tdata[9:0];
                        b_reg      <= s_tdata[19:10];
                        pos_reg[0] <= $signed(s_tdata[51:20]);
                        pos_reg[1] <= $signed(s_tdata[83:52]);
                        pos_reg[2] <= $signed(s_tdata[115:84]);
                        fo_reg[0]  <= 32'sd0;
                        fo_reg[1]  <= 32'sd0;
                        fo_reg[2]  <= 32'sd0;
                        vir_reg    <= 32'sd0;
                        hit_reg    <= 1'b0;
                        if (func_t'(s_tuser) == FN_CLEAR)
                        begin
                            energy_reg <= 32'sd0;
                            count_reg  <= 32'd0;
                        end
                    end
                end
                // fetch positions, then form wrapped displacements
                S_PRD:
                begin
                    if (step_reg >= 6'd1 && step_reg <= 6'd3)
                        pa_reg[step_reg[1:0] - 2'd1] <= pos_rdata;
                    if (step_reg >= 6'd4)
                        d_reg[step_reg[1:0]] <= wrap_d(pa_reg[step_reg[1:0]], pos_rdata,
                                                       box_reg);
                end
                // sum of squares, cutoff test, divider set-up
                S_SQ:
                begin
                    if (step_reg == 6'd1)
                        r2_reg <= 64'(prod_reg);
                    else if (step_reg == 6'd2 || step_reg == 6'd3)
                        r2_reg <= r2_reg + 64'(prod_reg);
                    else if (step_reg == 6'd4)
                    begin
                        hit_reg <= !(r2_reg > {17'd0, cut_reg, 16'd0});
                        r2q_reg <= r2q_c;
                        rem_reg <= 32'd0;
                        num_reg <= 34'h1_0000_0000 + {3'd0, r2q_c[31:1]};
                    end
                end
                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    rem_reg <= div_ge ? 32'(trial - {1'b0, r2q_reg}) : trial[31:0];
                    num_reg <= {num_reg[32:0], div_ge};
                end
                // product chain for force scale and energy
                S_MUL:
                begin
                    case (step_reg)
                        6'd1:  t_reg   <= qm;
                        6'd3:  r6i_reg <= qm;
                        6'd5:  t_reg   <= qm;
                        6'd7:  g_reg   <= qm;
                        6'd9:  t_reg   <= qm;
                        6'd10: t_reg   <= sat32(66'(t_reg) - 66'(shift_reg));
                        6'd11:
                        begin
                            energy_reg <= sat32(66'(energy_reg) + 66'(t_reg));
                            if (count_reg != 32'hFFFF_FFFF)
                                count_reg <= count_reg + 32'd1;
                            f_reg[0] <= qm;
                        end
                        6'd12: f_reg[1] <= qm;
                        6'd13: f_reg[2] <= qm;
                        default: t_reg <= t_reg;
                    endcase
                end
                // read back force of atom a, virial for read items
                S_OUT:
                begin
                    if (step_reg >= 6'd1 && step_reg <= 6'd3)
                        fo_reg[step_reg[1:0] - 2'd1] <= frc_rdata;
                    if (step_reg >= 6'd2 && func_reg == FN_READ)
                        vir_reg <= sat32(66'(vir_reg) + 66'(qm));
                end
                // present the result beat
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {count_reg, energy_reg, vir_reg,
                                         fo_reg[2], fo_reg[1], fo_reg[0]};
                        m_tuser_reg  <= hit_reg;
                    end
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    // no memory write while idle
    a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!pos_we && !frc_we))
        else $error("memory written while idle");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < r2q_reg))
        else $error("divider remainder out of range");

    // divisor never zero
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (r2q_reg != 32'd0))
        else $error("zero divisor");

    // an accepted item closes the input until it is done
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while busy");

endmodule
`default_nettype wire
